>>> sv/hape_pkg.sv
// Shared types, constants and the arctangent step table of the harmonic estimator.
`default_nettype none
package hape_pkg;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    localparam int CORDIC_STEPS  = 22;
    localparam int HALF_PI_UNITS = 8388608;
    localparam logic [17:0] AMP_MAX = 18'h3FFFF;

    typedef struct packed {
        logic               operation;
        logic [8:0]         bin_index;
        logic signed [15:0] bin_real;
        logic signed [15:0] bin_imag;
        logic [6:0]         harmonic_number;
        logic [15:0]        pitch_bins;
    } t_in;

    typedef struct packed {
        logic [6:0]         harmonic_out;
        logic [17:0]        amplitude;
        logic signed [15:0] phase;
    } t_out;

    // Angle of each micro-rotation, in units of pi/2^24.
    function automatic logic [22:0] atan_step(input logic [4:0] idx);
        logic [22:0] v;
        unique case (idx)
            5'd0:    v = 23'd4194304;
            5'd1:    v = 23'd2476042;
            5'd2:    v = 23'd1308273;
            5'd3:    v = 23'd664100;
            5'd4:    v = 23'd333339;
            5'd5:    v = 23'd166832;
            5'd6:    v = 23'd83436;
            5'd7:    v = 23'd41721;
            5'd8:    v = 23'd20861;
            5'd9:    v = 23'd10430;
            5'd10:   v = 23'd5215;
            5'd11:   v = 23'd2608;
            5'd12:   v = 23'd1304;
            5'd13:   v = 23'd652;
            5'd14:   v = 23'd326;
            5'd15:   v = 23'd163;
            5'd16:   v = 23'd81;
            5'd17:   v = 23'd41;
            5'd18:   v = 23'd20;
            5'd19:   v = 23'd10;
            5'd20:   v = 23'd5;
            5'd21:   v = 23'd3;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/harmonic_amplitude_phase_estimator_core.sv
// Top level: spectrum store, band sequencer with shared multiplier, square root and CORDIC.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//
// A load transaction writes one bin of the store if its index lies inside the store.
// In an estimate, the shared multiplier squares the real part and then the imaginary
// part of each band bin inside the store, the square root resolves one result bit a
// cycle, and the CORDIC turns once per cycle over 22 steps.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// The spectrum store has no reset: a bin is undefined until it is loaded.
// The finished result sits in an output register; a stalled output only blocks
// the next estimate at its very end, and loads are taken only while the sequencer idles.
`default_nettype none
module harmonic_amplitude_phase_estimator_core
    import hape_pkg::*;
#(
    parameter int BINS = 512
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int AW = $clog2(BINS);
    localparam int EW = AW + 32;
    localparam int XW = (AW > 9) ? AW + 1 : 10;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_EDGE, ST_RD, ST_SQR_RE, ST_SQR_IM, ST_ACC,
        ST_SQRT_GO, ST_SQRT_W, ST_CTR_RD, ST_CORD_GO, ST_CORD_W, ST_DONE
    } t_state;

    t_state r_state;

    // Spectrum store, one write port for loads and one registered read port.
    logic signed [15:0] mem_re [BINS];
    logic signed [15:0] mem_im [BINS];
    logic signed [15:0] r_rd_re;
    logic signed [15:0] r_rd_im;
    logic [AW-1:0]      rd_addr;
    logic [XW-1:0]      ld_idx;
    logic               wr_en;
    logic               in_acc;

    logic [6:0]         r_m;
    logic [15:0]        r_p;
    logic [AW:0]        r_idx;
    logic [AW:0]        r_hi;
    logic [AW-1:0]      r_b;
    logic               r_b_ok;
    logic [EW-1:0]      r_energy;
    logic [17:0]        r_amp;
    logic signed [15:0] r_phase;
    logic               r_out_vld;
    t_out               r_out;

    // Shared multiplier, registered at its output.
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] r_prod;

    // Band edge arithmetic from the product (2m-1)*P.
    logic signed [26:0] t_base;
    logic signed [26:0] ta;
    logic signed [26:0] tb;
    logic signed [26:0] tc;
    logic signed [26:0] am;
    logic signed [26:0] bm;
    logic signed [26:0] bc;

    logic               sqrt_done;
    logic [17:0]        sqrt_root;
    logic               cord_done;
    logic signed [15:0] cord_phase;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign ld_idx     = XW'(i_in_data.bin_index);
    assign wr_en      = in_acc && (i_in_data.operation == OP_LOAD) && (ld_idx < XW'(BINS));
    assign rd_addr    = (r_state == ST_CTR_RD) ? r_b : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_re[ld_idx[AW-1:0]] <= i_in_data.bin_real;
            mem_im[ld_idx[AW-1:0]] <= i_in_data.bin_imag;
        end
        r_rd_re <= mem_re[rd_addr];
        r_rd_im <= mem_im[rd_addr];
    end

    always_comb begin
        unique case (r_state)
            ST_MUL: begin
                mul_a = $signed({2'b00, r_m, 1'b0}) - 18'sd1;
                mul_b = $signed({2'b00, r_p});
            end
            ST_SQR_IM: begin
                mul_a = 18'(r_rd_im);
                mul_b = 18'(r_rd_im);
            end
            default: begin
                mul_a = 18'(r_rd_re);
                mul_b = 18'(r_rd_re);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign t_base = r_prod[26:0];
    assign ta     = t_base + 27'sd1024;
    assign tb     = t_base + $signed({10'b0, r_p, 1'b0}) + 27'sd1024;
    assign tc     = t_base + $signed({11'b0, r_p}) + 27'sd1024;
    assign am     = ta >>> 11;
    assign bm     = tb >>> 11;
    assign bc     = tc >>> 11;

    // Sequencer, result registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // In the done state the output register is handled below.
            if (o_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in_data.operation == OP_ESTIMATE) begin
                        r_m     <= i_in_data.harmonic_number;
                        r_p     <= i_in_data.pitch_bins;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_EDGE;
                end
                ST_EDGE: begin
                    // Band bins below zero or past the store are skipped.
                    if (am < 0) begin
                        r_idx <= '0;
                    end else if (am > 27'(BINS)) begin
                        r_idx <= (AW+1)'(BINS);
                    end else begin
                        r_idx <= am[AW:0];
                    end
                    if (bm < 0) begin
                        r_hi <= '0;
                    end else if (bm > 27'(BINS)) begin
                        r_hi <= (AW+1)'(BINS);
                    end else begin
                        r_hi <= bm[AW:0];
                    end
                    r_b      <= bc[AW-1:0];
                    r_b_ok   <= (bc < 27'(BINS));
                    r_energy <= '0;
                    r_state  <= ST_RD;
                end
                ST_RD: begin
                    r_state <= (r_idx < r_hi) ? ST_SQR_RE : ST_SQRT_GO;
                end
                ST_SQR_RE: begin
                    r_state <= ST_SQR_IM;
                end
                ST_SQR_IM: begin
                    r_energy <= r_energy + EW'(r_prod[31:0]);
                    r_state  <= ST_ACC;
                end
                ST_ACC: begin
                    r_energy <= r_energy + EW'(r_prod[31:0]);
                    r_idx    <= r_idx + 1'b1;
                    r_state  <= ST_RD;
                end
                ST_SQRT_GO: begin
                    r_state <= ST_SQRT_W;
                end
                ST_SQRT_W: begin
                    if (sqrt_done) begin
                        r_amp   <= sqrt_root;
                        r_state <= ST_CTR_RD;
                    end
                end
                ST_CTR_RD: begin
                    r_state <= ST_CORD_GO;
                end
                ST_CORD_GO: begin
                    if (r_b_ok) begin
                        r_state <= ST_CORD_W;
                    end else begin
                        r_phase <= '0;
                        r_state <= ST_DONE;
                    end
                end
                ST_CORD_W: begin
                    if (cord_done) begin
                        r_phase <= cord_phase;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out.harmonic_out <= r_m;
                        r_out.amplitude    <= r_amp;
                        r_out.phase        <= r_phase;
                        r_out_vld          <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    hape_isqrt #(
        .EW(EW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SQRT_GO),
        .i_value (r_energy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    hape_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == ST_CORD_GO) && r_b_ok),
        .i_re    (r_rd_re),
        .i_im    (r_rd_im),
        .o_done  (cord_done),
        .o_phase (cord_phase)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // An accepted estimate always starts with the edge multiply.
    a_est_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.operation == OP_ESTIMATE) |=> (r_state == ST_MUL))
        else $error("estimate did not start the edge multiply");

    // The square root only finishes while the sequencer waits for it.
    a_sqrt_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == ST_SQRT_W))
        else $error("square root finished outside its wait state");

    // A bin is squared only while the walk is inside the band.
    a_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQR_RE) |-> (r_idx < r_hi))
        else $error("band walk beyond its upper edge");

endmodule
`default_nettype wire

>>> sv/hape_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`default_nettype none
module hape_isqrt
    import hape_pkg::*;
#(
    parameter int EW = 41
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [EW-1:0] i_value,
    output logic               o_done,
    output logic [17:0]        o_root
);

    localparam int NI = (EW + 1) / 2;
    localparam int RW = NI + 3;
    localparam int CW = $clog2(NI + 1);

    logic [2*NI-1:0] r_val;
    logic [RW-1:0]   r_rem;
    logic [NI-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          take;

    assign rem_sh = {r_rem[RW-3:0], r_val[2*NI-1 -: 2]};
    assign trial  = RW'({r_root, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_val  <= (2*NI)'(i_value);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(NI);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_val <= {r_val[2*NI-3:0], 2'b00};
                if (take) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[NI-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[NI-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = (r_root > NI'(AMP_MAX)) ? AMP_MAX : r_root[17:0];

endmodule
`default_nettype wire

>>> sv/hape_cordic.sv
// Iterative vectoring CORDIC that returns atan2 as a Q15 fraction of pi.
`default_nettype none
module hape_cordic
    import hape_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_re,
    input  wire logic signed [15:0] i_im,
    output logic                    o_done,
    output logic signed [15:0]      o_phase
);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [26:0] r_z;
    logic [4:0]         r_i;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic signed [15:0] r_phase;

    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [26:0] at;
    logic signed [26:0] zr;

    assign xs = {{4{i_re[15]}}, i_re, 14'b0};
    assign ys = {{4{i_im[15]}}, i_im, 14'b0};
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = $signed({4'b0, atan_step(r_i)});
    assign zr = (r_z + 27'sd256) >>> 9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_re == 16'sd0 && i_im == 16'sd0) begin
                    r_phase <= '0;
                    r_done  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_i    <= '0;
                    if (xs < 0 && ys >= 0) begin
                        r_x <= ys;
                        r_y <= -xs;
                        r_z <= 27'(HALF_PI_UNITS);
                    end else if (xs < 0) begin
                        r_x <= -ys;
                        r_y <= xs;
                        r_z <= -27'(HALF_PI_UNITS);
                    end else begin
                        r_x <= xs;
                        r_y <= ys;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else if (r_y < 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                // Round to Q15 and clamp; an angle of exactly pi lands on the top code.
                if (zr > 27'sd32767) begin
                    r_phase <= 16'sh7FFF;
                end else if (zr < -27'sd32768) begin
                    r_phase <= 16'sh8000;
                end else begin
                    r_phase <= zr[15:0];
                end
                r_done <= 1'b1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_phase = r_phase;

endmodule
`default_nettype wire

>>> dv/hape_scoreboard.sv
// Watches both channels of the harmonic estimator, predicts each result and compares it.
`default_nettype none
module hape_scoreboard
    import hape_pkg::*;
#(
    parameter int BINS = 512
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  wire t_out i_out_data,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ARC_STEP [22] = '{
        4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3
    };

    logic signed [15:0] spec_re [BINS];
    logic signed [15:0] spec_im [BINS];
    t_out               harmonic_queue [$];

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic signed [15:0] bin_phase(input longint re, input longint im);
        longint x;
        longint y;
        longint z;
        longint t;
        longint q;
        longint dx;
        longint dy;
        if (re == 0 && im == 0) begin
            return 16'sd0;
        end
        x = re * 16384;
        y = im * 16384;
        z = 0;
        // Fold the left half plane onto the right one by a quarter turn.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI_UNITS;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_UNITS;
            end
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
                x += dx; y -= dy; z += ARC_STEP[k];
            end else if (y < 0) begin
                x -= dx; y += dy; z -= ARC_STEP[k];
            end
        end
        q = (z + 256) >>> 9;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic t_out estimate_harmonic(input t_in item);
        t_out            res;
        longint          m;
        longint          p;
        longint          lo;
        longint          hi;
        longint          ctr;
        longint unsigned energy;
        longint unsigned amp;
        m = item.harmonic_number;
        p = item.pitch_bins;
        lo = ((2 * m - 1) * p + 1024) >>> 11;
        hi = ((2 * m + 1) * p + 1024) >>> 11;
        ctr = (m * p + 512) >>> 10;
        if (lo < 0) lo = 0;
        if (hi > BINS) hi = BINS;
        energy = 0;
        for (longint i = lo; i < hi; i++) begin
            energy += longint'(spec_re[i]) * longint'(spec_re[i])
                    + longint'(spec_im[i]) * longint'(spec_im[i]);
        end
        amp = floor_sqrt(energy);
        if (amp > AMP_MAX) amp = AMP_MAX;
        res.harmonic_out = item.harmonic_number;
        res.amplitude    = amp[17:0];
        res.phase        = (ctr >= 0 && ctr < BINS)
                         ? bin_phase(spec_re[ctr], spec_im[ctr]) : 16'sd0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_errors <= 0;
            harmonic_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (harmonic_queue.size() == 0) begin
                    $display("%0t: result with none expected: %p", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = harmonic_queue.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, want, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.operation == OP_LOAD) begin
                    if (i_in_data.bin_index < BINS) begin
                        spec_re[i_in_data.bin_index] = i_in_data.bin_real;
                        spec_im[i_in_data.bin_index] = i_in_data.bin_imag;
                    end
                end else begin
                    harmonic_queue.push_back(estimate_harmonic(i_in_data));
                end
            end
        end
    end

    assign o_pending = harmonic_queue.size();

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Top of the harmonic estimator testbench: clock, reset, stimulus and verdict.
`default_nettype none
module testbench;
    import hape_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS       = 512;
    localparam int RAND_ITEMS = 1300;
    localparam int QUIET_TAIL = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    int   errors;
    int   pending;

    // The tail of the run has no idling on either side; the long hold-off on
    // the result side is requested once, after the directed part.
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    harmonic_amplitude_phase_estimator_core #(.BINS(BINS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    hape_scoreboard #(.BINS(BINS)) u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Offer one transaction from a falling edge and hold it until it is taken.
    // Between transactions a random burst of idle cycles may be inserted.
    task automatic offer(input t_in item);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_bin(input int idx, input logic signed [15:0] re,
                            input logic signed [15:0] im);
        t_in item;
        item.operation       = OP_LOAD;
        item.bin_index       = idx[8:0];
        item.bin_real        = re;
        item.bin_imag        = im;
        item.harmonic_number = 7'($urandom());
        item.pitch_bins      = 16'($urandom());
        offer(item);
    endtask

    task automatic estimate(input int m, input int p);
        t_in item;
        item.operation       = OP_ESTIMATE;
        item.bin_index       = 9'($urandom());
        item.bin_real        = 16'($urandom());
        item.bin_imag        = 16'($urandom());
        item.harmonic_number = m[6:0];
        item.pitch_bins      = p[15:0];
        offer(item);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial begin
        bit held;
        int burst;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (600) @(negedge i_clk);
            end else if (quiet) begin
                out_ready = 1'b1;
            end else begin
                burst = $urandom_range(1, 10);
                out_ready = ($urandom_range(0, 9) < 7);
                repeat (burst - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        int m;
        int p;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Fill the whole store at full negative scale so no estimate ever
        // reads a bin that was never loaded.
        for (int i = 0; i < BINS; i++) begin
            load_bin(i, 16'sh8000, 16'sh8000);
        end

        // Directed part. A wide band of full-scale bins overflows the amplitude.
        estimate(1, 65535);
        load_bin(0, 16'sd0, 16'sd0);
        load_bin(1, 16'sh8000, 16'sd0);
        load_bin(2, 16'sh7FFF, 16'sh7FFF);
        load_bin(3, 16'sh8000, 16'sh7FFF);
        load_bin(511, 16'sh7FFF, 16'sh8000);
        estimate(1, 1024);     // centre bin lies on the negative real axis: pi
        estimate(1, 0);        // empty band, zero vector at the centre
        estimate(0, 65535);    // harmonic zero, band starts below the store
        estimate(127, 65535);  // centre and band past the end of the store
        estimate(1, 2048);
        estimate(1, 3072);
        estimate(127, 4096);   // band of bins 506 to 509, just below the top of the store
        estimate(64, 8191);    // band clipped at the top of the store, centre one past the last bin
        estimate(127, 0);
        hold_req = 1'b1;

        // Random part: mostly narrow bands, now and then the full pitch range.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
            if ($urandom_range(0, 1) == 0) begin
                load_bin($urandom_range(0, BINS - 1), pick_sample(), pick_sample());
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    m = $urandom_range(0, 127);
                    p = $urandom_range(0, 65535);
                end else begin
                    m = $urandom_range(0, 40);
                    p = $urandom_range(0, 16383);
                end
                estimate(m, p);
            end
        end
        in_valid = 1'b0;

        wait (pending == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
